// ----- src/clsg_pkg.sv -----
// Shared types, constants and the modular fold for the combined LCG generator.
// Used by clsg_front, clsg_engine and the top level combined_lcg_shuffled_generator.
package clsg_pkg;

  localparam int unsigned DataW = 31;

  // Generator moduli and multipliers
  localparam logic [31:0] ModA = 32'd2147483563;
  localparam logic [31:0] ModB = 32'd2147483399;
  localparam logic [15:0] MulA = 16'd40014;
  localparam logic [15:0] MulB = 16'd40692;
  // 2^31 mod m for each modulus
  localparam logic [7:0]  FoldA = 8'd85;
  localparam logic [7:0]  FoldB = 8'd249;
  localparam logic [31:0] RangeTop = 32'd2147483562;
  localparam logic [DataW-1:0] SecondReset = 31'd123456789;
  localparam int unsigned ProdW = DataW + 16;

  // Input opcode value for reseed
  localparam logic OpReseed = 1'b1;

  typedef enum logic {
    CMD_DRAW   = 1'b0,
    CMD_RESEED = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [DataW-1:0] seed;
  } cmd_t;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_DRAW_WAIT = 7'b0000010,
    S_DRAW_READ = 7'b0000100,
    S_DRAW_MIX  = 7'b0001000,
    S_SEED_MUL  = 7'b0010000,
    S_SEED_RED  = 7'b0100000,
    S_SETTLE    = 7'b1000000
  } eng_state_e;

  // Reduce a registered product mul*z (z < 2^31, mul < 2^16) modulo m = 2^31 - k.
  // hi*k + lo stays below 2m, so one conditional subtract finishes it.
  function automatic logic [DataW-1:0] lehmer_fold(input logic [ProdW-1:0] prod,
                                                   input logic [7:0]       fold,
                                                   input logic [31:0]      modulus);
    logic [31:0] sum;
    sum = 32'(prod[DataW-1:0]) + 32'(prod[ProdW-1:DataW]) * 32'(fold);
    return (sum >= modulus) ? DataW'(sum - modulus) : sum[DataW-1:0];
  endfunction

endpackage

// ----- src/combined_lcg_shuffled_generator.sv -----
// Draw: a popped command steps through the wait, read and mix states and back to idle; the
// result register loads on leaving mix, which holds while the output stalls. Reseed: each
// generator step is a multiply state then a fold state, for WARMUP_STEPS+TABLE_DEPTH steps.
// A 2-entry command queue keeps accepting while the engine or output stalls, until it is full.
// Reset: generators 1 and 123456789, last output 0, table reads zero via per-entry
// valid bits; no clearing pass.
module combined_lcg_shuffled_generator
  import clsg_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = 64,
  parameter int unsigned WARMUP_STEPS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [30:0] seed_magnitude, [31] zero
  input  logic        s_axis_tuser_i,  // [0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o   // [30:0] random_value, [61:31] first_generator_state
);

  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;
  logic [DataW-1:0] rand_val;
  logic [DataW-1:0] first_val;

  clsg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_seed_i    (s_axis_tdata_i[DataW-1:0]),
    .s_op_i      (s_axis_tuser_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  clsg_engine #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .WARMUP_STEPS (WARMUP_STEPS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .rand_o      (rand_val),
    .first_o     (first_val)
  );

  assign m_axis_tdata_o = {2'b00, first_val, rand_val};

  // Engine pops only a queued command
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> cmd_valid)
    else $error("engine popped an empty command queue");

  // A full queue is never empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) !s_axis_tready_o |-> cmd_valid)
    else $error("queue reports full with no command held");

  // Every delivered value lies within the generator range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (rand_val != '0) && (32'(rand_val) <= RangeTop))
    else $error("random value out of range");

endmodule

// ----- src/clsg_front.sv -----
// Front end: accepts input items, classifies them into commands and queues them.
// Depends on clsg_pkg for the command type and opcode constant.
module clsg_front
  import clsg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [DataW-1:0] s_seed_i,
  input  logic             s_op_i,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  logic             cmd_pop_i
);

  cmd_t       queue_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  cmd_t       cmd_in;

  // Classify: opcode to command kind, zero seed becomes one
  always_comb begin
    cmd_in.kind = (s_op_i == OpReseed) ? CMD_RESEED : CMD_DRAW;
    cmd_in.seed = (s_seed_i == '0) ? DataW'(1) : s_seed_i;
  end

  assign s_tready_o  = (count_q != 2'd2);
  assign push        = s_tvalid_i && s_tready_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = queue_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ cmd_pop_i;
    count_d  = count_q + 2'(push) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ----- src/clsg_engine.sv -----
// Back end: runs both generators, the reseed sequence and the shuffle table.
// Depends on clsg_pkg for constants, the modular fold and the state type.
module clsg_engine
  import clsg_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = 64,
  parameter int unsigned WARMUP_STEPS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] rand_o,
  output logic [DataW-1:0] first_o
);

  localparam int unsigned IdxW  = $clog2(TABLE_DEPTH);
  localparam int unsigned QW    = IdxW + 1;
  localparam int unsigned PW    = 32 + QW;
  localparam int unsigned Total = TABLE_DEPTH + WARMUP_STEPS;
  localparam int unsigned CntW  = $clog2(Total);
  localparam longint unsigned SlotDiv = 64'd1 + 64'd2147483562 / 64'(TABLE_DEPTH);
  localparam longint unsigned Recip   = (64'd1 << 32) / SlotDiv;

  eng_state_e state_q, state_d;

  logic [DataW-1:0] a_q, b_q, last_q;
  logic [ProdW-1:0] prod_a_q, prod_b_q;
  logic [PW-1:0]    qprod_q;
  logic [IdxW-1:0]  slot_q, slot_d;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] a_red, b_red;
  logic [QW-1:0]    q_est, q_fix;
  logic [31:0]      rem;
  logic [31:0]      diff;
  logic [DataW-1:0] mixed;
  logic             out_free;
  logic             mix_fire;
  logic             seed_write;
  logic             seed_done;

  logic [DataW-1:0]       tbl_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tbl_vld_q;
  logic [DataW-1:0]       rd_data_q;
  logic                   rd_vld_q;
  logic                   tbl_we;
  logic [IdxW-1:0]        tbl_waddr;
  logic [DataW-1:0]       tbl_wdata;

  logic             out_valid_q;
  logic [DataW-1:0] out_rand_q, out_first_q;

  // Reduce registered products
  assign a_red = lehmer_fold(prod_a_q, FoldA, ModA);
  assign b_red = lehmer_fold(prod_b_q, FoldB, ModB);

  // Slot from last output: reciprocal estimate, then one correction step
  always_comb begin
    q_est = qprod_q[32 +: QW];
    rem   = 32'(last_q) - 32'(q_est) * 32'(SlotDiv);
    q_fix = q_est + QW'(rem >= 32'(SlotDiv));
    slot_d = (q_fix >= QW'(TABLE_DEPTH)) ? IdxW'(TABLE_DEPTH - 1) : q_fix[IdxW-1:0];
  end

  // Combine table word with second generator, wrap into range
  always_comb begin
    diff  = 32'(rd_vld_q ? rd_data_q : '0) - 32'(b_q);
    mixed = (rd_data_q > b_q && rd_vld_q) ? diff[DataW-1:0] : DataW'(diff + RangeTop);
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign mix_fire   = (state_q == S_DRAW_MIX) && out_free;
  assign seed_write = (state_q == S_SEED_RED) &&
                      ({1'b0, cnt_q} < (CntW + 1)'(TABLE_DEPTH));
  assign seed_done  = (state_q == S_SEED_RED) && (cnt_q == '0);
  assign cmd_pop_o  = (state_q == S_IDLE) && cmd_valid_i;

  // Sequence draws and reseeds
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.kind == CMD_RESEED) ? S_SEED_MUL : S_DRAW_WAIT;
        end
      end
      S_DRAW_WAIT: state_d = S_DRAW_READ;
      S_DRAW_READ: state_d = S_DRAW_MIX;
      S_DRAW_MIX: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SEED_MUL: state_d = S_SEED_RED;
      S_SEED_RED: state_d = seed_done ? S_SETTLE : S_SEED_MUL;
      S_SETTLE:   state_d = S_DRAW_WAIT;
      default:    state_d = S_IDLE;
    endcase
  end

  // Control and generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      a_q         <= DataW'(1);
      b_q         <= SecondReset;
      last_q      <= '0;
      cnt_q       <= '0;
      qprod_q     <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      tbl_vld_q   <= '0;
    end else begin
      state_q <= state_d;
      qprod_q <= PW'(last_q) * PW'(Recip);
      slot_q  <= slot_d;
      if (cmd_pop_o && cmd_i.kind == CMD_RESEED) begin
        a_q   <= cmd_i.seed;
        b_q   <= cmd_i.seed;
        cnt_q <= CntW'(Total - 1);
      end
      if (state_q == S_DRAW_READ) begin
        a_q <= a_red;
        b_q <= b_red;
      end
      if (state_q == S_SEED_RED) begin
        a_q   <= a_red;
        cnt_q <= cnt_q - CntW'(1);
        if (seed_done) begin
          last_q <= a_red;
        end
      end
      if (mix_fire) begin
        last_q <= mixed;
      end
      if (tbl_we) begin
        tbl_vld_q[tbl_waddr] <= 1'b1;
      end
      if (mix_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Free-running constant multipliers
  always_ff @(posedge clk_i) begin
    prod_a_q <= ProdW'(a_q) * ProdW'(MulA);
    prod_b_q <= ProdW'(b_q) * ProdW'(MulB);
  end

  // Shuffle table: write on refill or fill step, registered read at the slot
  assign tbl_we    = mix_fire || seed_write;
  assign tbl_waddr = mix_fire ? slot_q : cnt_q[IdxW-1:0];
  assign tbl_wdata = mix_fire ? a_q : a_red;

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    rd_data_q <= tbl_mem[slot_q];
    rd_vld_q  <= tbl_vld_q[slot_q];
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (mix_fire) begin
      out_rand_q  <= mixed;
      out_first_q <= a_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rand_o      = out_rand_q;
  assign first_o     = out_first_q;

endmodule
